// ----- rtl/lcf_pkg.sv -----
// Package for the CRC-32C link framer: command item type, register and
// mode codes, CRC constants and the one-byte CRC-32C update.
// No dependencies.
package lcf_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_SYNC_FIRST  = 2'd0,
        REG_SYNC_SECOND = 2'd1,
        REG_MAX_PAYLOAD = 2'd2
    } reg_idx_t;

    localparam logic [7:0]  SYNC_RESET        = 8'd0;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4096;

    // Input item modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // CRC-32C, reflected
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Header command: 8 header bytes then 4 header CRC bytes
    localparam logic [3:0] HDR_LAST_BYTE  = 4'd7;
    localparam logic [3:0] HDR_CRC_END    = 4'd11;
    localparam logic [3:0] HDR_EMPTY_END  = 4'd15;
    localparam logic [3:0] DATA_CRC_END   = 4'd4;

    typedef enum logic [1:0] {
        CMD_REJECT = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_DATA   = 2'd2
    } cmd_kind_t;

    // One classified item; flag is "empty payload" for a header,
    // "last payload byte" for data
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] dest;
        logic [15:0] src;
        logic [15:0] len;
        logic [7:0]  data;
        logic        flag;
    } cmd_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- rtl/lcf_front.sv -----
// Front end of the framer: accepts input items, tracks frame state and
// classifies each item that is not dropped into a command for the back end.
// Depends on lcf_pkg.
module lcf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              mode,
    input  logic [15:0]       dest_addr,
    input  logic [15:0]       src_addr,
    input  logic [15:0]       payload_len,
    input  logic [7:0]        data_byte,
    input  logic [15:0]       max_payload,
    output logic              push,
    output lcf_pkg::cmd_t     push_cmd
);
    import lcf_pkg::*;

    logic        open_reg, open_next;
    logic        drop_reg, drop_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] left_dec;
    logic        accept;

    assign accept   = in_valid && in_ready;
    assign left_dec = (left_reg != 16'd0) ? left_reg - 16'd1 : left_reg;

    // Classification and next frame state
    always_comb
    begin
        open_next     = open_reg;
        drop_next     = drop_reg;
        left_next     = left_reg;
        push          = 1'b0;
        push_cmd      = '0;
        push_cmd.dest = dest_addr;
        push_cmd.src  = src_addr;
        push_cmd.len  = payload_len;
        push_cmd.data = data_byte;
        if (accept)
        begin
            if (mode == MODE_START)
            begin
                push      = 1'b1;
                left_next = payload_len;
                if (payload_len > max_payload)
                begin
                    push_cmd.kind = CMD_REJECT;
                    open_next     = 1'b0;
                    drop_next     = 1'b1;
                end
                else
                begin
                    push_cmd.kind = CMD_HEADER;
                    push_cmd.flag = (payload_len == 16'd0);
                    open_next     = (payload_len != 16'd0);
                    drop_next     = 1'b0;
                end
            end
            else if (drop_reg)
            begin
                left_next = left_dec;
                drop_next = (left_dec != 16'd0);
            end
            else if (open_reg)
            begin
                push          = 1'b1;
                push_cmd.kind = CMD_DATA;
                push_cmd.flag = (left_dec == 16'd0);
                left_next     = left_dec;
                open_next     = (left_dec != 16'd0);
            end
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            drop_reg <= 1'b0;
            left_reg <= 16'd0;
        end
        else
        begin
            open_reg <= open_next;
            drop_reg <= drop_next;
            left_reg <= left_next;
        end
    end

endmodule

// ----- rtl/lcf_cmd_fifo.sv -----
// Short command queue between the framer's front and back ends.
// Depends on lcf_pkg.
module lcf_cmd_fifo #(
    parameter int Depth = lcf_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lcf_pkg::cmd_t     push_cmd,
    input  logic              pop,
    output logic              full,
    output lcf_pkg::q_head_t  head
);
    import lcf_pkg::*;

    localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

    cmd_t            slot_reg [Depth];
    logic [IdxW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IdxW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CntW'(Depth));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- rtl/lcf_back.sv -----
// Back end of the framer: walks each queued command byte by byte,
// runs the CRC-32C and drives the registered output channel.
// Depends on lcf_pkg.
module lcf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lcf_pkg::q_head_t  head,
    output logic              pop,
    input  logic [7:0]        sync_first,
    input  logic [7:0]        sync_second,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              frame_end,
    output logic              rejected
);
    import lcf_pkg::*;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg, byte_next;
    logic        frame_end_reg, end_next;
    logic        rejected_reg, rej_next;
    logic [3:0]  step_reg, step_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] crc_out;
    logic [7:0]  hdr_byte, crc_byte_sel;
    logic [1:0]  crc_idx;
    logic        last_step;
    logic        load, fire;

    assign load = !out_valid_reg || out_ready;
    assign fire = load && head.valid;
    assign pop  = fire && last_step;

    assign crc_out = ~crc_reg;
    assign crc_idx = (head.cmd.kind == CMD_DATA) ? step_reg[1:0] - 2'd1 : step_reg[1:0];

    // Header byte for the current step
    always_comb
    begin
        unique case (step_reg[2:0])
            3'd0:    hdr_byte = sync_first;
            3'd1:    hdr_byte = sync_second;
            3'd2:    hdr_byte = head.cmd.dest[15:8];
            3'd3:    hdr_byte = head.cmd.dest[7:0];
            3'd4:    hdr_byte = head.cmd.src[15:8];
            3'd5:    hdr_byte = head.cmd.src[7:0];
            3'd6:    hdr_byte = head.cmd.len[15:8];
            default: hdr_byte = head.cmd.len[7:0];
        endcase
    end

    // Big-endian CRC byte select
    always_comb
    begin
        unique case (crc_idx)
            2'd0:    crc_byte_sel = crc_out[31:24];
            2'd1:    crc_byte_sel = crc_out[23:16];
            2'd2:    crc_byte_sel = crc_out[15:8];
            default: crc_byte_sel = crc_out[7:0];
        endcase
    end

    // Byte sequencing per command kind
    always_comb
    begin
        byte_next = 8'd0;
        end_next  = 1'b0;
        rej_next  = 1'b0;
        crc_next  = crc_reg;
        last_step = 1'b1;
        unique case (head.cmd.kind)
            CMD_REJECT:
            begin
                end_next = 1'b1;
                rej_next = 1'b1;
            end
            CMD_HEADER:
            begin
                if (step_reg <= HDR_LAST_BYTE)
                begin
                    byte_next = hdr_byte;
                    crc_next  = crc32c_byte((step_reg == 4'd0) ? CRC_INIT : crc_reg,
                                            hdr_byte);
                end
                else
                begin
                    byte_next = crc_byte_sel;
                    // body CRC starts fresh after the header CRC
                    if (step_reg == HDR_CRC_END)
                        crc_next = CRC_INIT;
                end
                last_step = head.cmd.flag ? (step_reg == HDR_EMPTY_END)
                                          : (step_reg == HDR_CRC_END);
                end_next  = head.cmd.flag && (step_reg == HDR_EMPTY_END);
            end
            CMD_DATA:
            begin
                if (step_reg == 4'd0)
                begin
                    byte_next = head.cmd.data;
                    crc_next  = crc32c_byte(crc_reg, head.cmd.data);
                end
                else
                begin
                    byte_next = crc_byte_sel;
                end
                last_step = head.cmd.flag ? (step_reg == DATA_CRC_END)
                                          : (step_reg == 4'd0);
                end_next  = head.cmd.flag && (step_reg == DATA_CRC_END);
            end
            default:
            begin
                last_step = 1'b1;
            end
        endcase
    end

    assign step_next = last_step ? 4'd0 : step_reg + 4'd1;

    // Sequencer state and CRC register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                step_reg      <= step_next;
                crc_reg       <= crc_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg  <= byte_next;
            frame_end_reg <= end_next;
            rejected_reg  <= rej_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign rejected  = rejected_reg;

endmodule

// ----- rtl/link_frame_crc32c_framer.sv -----
// Top level of the CRC-32C link framer: configuration registers and the
// front end, command queue and back end. Depends on lcf_pkg, lcf_front,
// lcf_cmd_fifo and lcf_back.
//
//   Channel   Direction  Handshake            Payload
//   in        sink       in_valid/in_ready    mode, dest_addr, src_addr, payload_len, data_byte
//   out       source     out_valid/out_ready  out_byte, frame_end, rejected
//   cfg       APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// The back end sends one byte per cycle while the output is not stalled and a
// command is queued: a payload item gives one byte, or five when it closes
// the frame; a start item gives 12 bytes (16 for an empty payload, 1 for a
// rejection). Input items that give no bytes take no queue slot. The front end
// accepts one item a cycle while the command queue has room, so it runs ahead
// of a stalled output. Reset clears frame state and the queue; there is no clearing pass.
module link_frame_crc32c_framer #(
    parameter int QueueDepth = lcf_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [15:0]                    dest_addr,
    input  logic [15:0]                    src_addr,
    input  logic [15:0]                    payload_len,
    input  logic [7:0]                     data_byte,
    // result items
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_byte,
    output logic                           frame_end,
    output logic                           rejected,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lcf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lcf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lcf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lcf_pkg::*;

    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [15:0] max_payload_reg;
    logic        cfg_write;
    reg_idx_t    reg_idx;
    logic        queue_full;
    logic        push;
    cmd_t        push_cmd;
    logic        pop;
    q_head_t     head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_RESET;
            sync_second_reg <= SYNC_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_SYNC_FIRST:  sync_first_reg  <= pwdata[7:0];
                REG_SYNC_SECOND: sync_second_reg <= pwdata[7:0];
                REG_MAX_PAYLOAD: max_payload_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_SYNC_FIRST:  prdata = {24'd0, sync_first_reg};
            REG_SYNC_SECOND: prdata = {24'd0, sync_second_reg};
            REG_MAX_PAYLOAD: prdata = {16'd0, max_payload_reg};
            default:         prdata = '0;
        endcase
    end

    assign in_ready = !queue_full;

    lcf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .dest_addr   (dest_addr),
        .src_addr    (src_addr),
        .payload_len (payload_len),
        .data_byte   (data_byte),
        .max_payload (max_payload_reg),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    lcf_cmd_fifo #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (queue_full),
        .head     (head)
    );

    lcf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .frame_end   (frame_end),
        .rejected    (rejected)
    );

endmodule

// ----- tb/lcf_frame_checker.sv -----
`timescale 1ns / 1ps
// Frame checker for the CRC-32C link framer: snoops the config port and both
// item channels, predicts the output byte stream and compares it in order.
// Depends on lcf_pkg for register codes, modes and CRC constants.
module lcf_frame_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           mode,
    input  logic [15:0]                    dest_addr,
    input  logic [15:0]                    src_addr,
    input  logic [15:0]                    payload_len,
    input  logic [7:0]                     data_byte,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [7:0]                     out_byte,
    input  logic                           frame_end,
    input  logic                           rejected,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lcf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lcf_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                           pready,
    output int                             fail_count,
    output int                             pending
);
    import lcf_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       rejected;
    } frame_byte_t;

    // predicted output bytes, oldest first
    frame_byte_t bytes_due[$];

    // shadow registers
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    logic [15:0] max_len;

    // shadow frame state
    logic        in_frame;
    logic        dropping;
    logic [15:0] left;
    logic [31:0] body_crc;

    int          errs;
    frame_byte_t want;

    // reflected CRC-32C, one byte
    function automatic logic [31:0] crc32c_next(input logic [31:0] c_in,
                                                input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic last, input logic rej);
        frame_byte_t r;
        r.out_byte  = b;
        r.frame_end = last;
        r.rejected  = rej;
        bytes_due.push_back(r);
    endtask

    // big-endian CRC trailer
    task automatic add_crc(input logic [31:0] c, input logic last);
        add_byte(c[31:24], 1'b0, 1'b0);
        add_byte(c[23:16], 1'b0, 1'b0);
        add_byte(c[15:8],  1'b0, 1'b0);
        add_byte(c[7:0],   last, 1'b0);
    endtask

    task automatic predict_frame_bytes(input logic m, input logic [15:0] dst,
                                       input logic [15:0] src, input logic [15:0] len,
                                       input logic [7:0] d);
        logic [7:0]  hdr [0:7];
        logic [31:0] crc;
        if (m == MODE_START)
        begin
            // a start always drops whatever frame was in progress
            in_frame = 1'b0;
            dropping = 1'b0;
            body_crc = CRC_INIT;
            if (len > max_len)
            begin
                add_byte(8'h00, 1'b1, 1'b1);
                dropping = 1'b1;
                left     = len;
            end
            else
            begin
                hdr[0] = sync_a;
                hdr[1] = sync_b;
                hdr[2] = dst[15:8];
                hdr[3] = dst[7:0];
                hdr[4] = src[15:8];
                hdr[5] = src[7:0];
                hdr[6] = len[15:8];
                hdr[7] = len[7:0];
                crc = CRC_INIT;
                for (int k = 0; k < 8; k++)
                begin
                    crc = crc32c_next(crc, hdr[k]);
                    add_byte(hdr[k], 1'b0, 1'b0);
                end
                add_crc(crc ^ CRC_INIT, 1'b0);
                left = len;
                if (len == 16'd0)
                    add_crc(32'h0000_0000, 1'b1);
                else
                    in_frame = 1'b1;
            end
        end
        else if (dropping)
        begin
            // rejected payload: swallowed without output
            if (left != 16'd0)
                left = left - 16'd1;
            if (left == 16'd0)
                dropping = 1'b0;
        end
        else if (in_frame)
        begin
            body_crc = crc32c_next(body_crc, d);
            add_byte(d, 1'b0, 1'b0);
            if (left != 16'd0)
                left = left - 16'd1;
            if (left == 16'd0)
            begin
                add_crc(body_crc ^ CRC_INIT, 1'b1);
                in_frame = 1'b0;
                body_crc = CRC_INIT;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_a   = SYNC_RESET;
            sync_b   = SYNC_RESET;
            max_len  = MAX_PAYLOAD_RESET;
            in_frame = 1'b0;
            dropping = 1'b0;
            left     = 16'd0;
            body_crc = CRC_INIT;
            errs     = 0;
            bytes_due.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
                    REG_SYNC_FIRST:  sync_a  = pwdata[7:0];
                    REG_SYNC_SECOND: sync_b  = pwdata[7:0];
                    REG_MAX_PAYLOAD: max_len = pwdata[15:0];
                    default: ;
                endcase
            end

            // accepted input item
            if (in_valid && in_ready)
                predict_frame_bytes(mode, dest_addr, src_addr, payload_len, data_byte);

            // accepted output item
            if (out_valid && out_ready)
            begin
                if (bytes_due.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected item: byte %02h end %0b rej %0b",
                             $time, out_byte, frame_end, rejected);
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (want.out_byte !== out_byte || want.frame_end !== frame_end ||
                        want.rejected !== rejected)
                    begin
                        errs++;
                        $display("%0t: expected %02h/%0b/%0b, got %02h/%0b/%0b (byte/end/rej)",
                                 $time, want.out_byte, want.frame_end, want.rejected,
                                 out_byte, frame_end, rejected);
                    end
                end
            end

            pending    <= bytes_due.size();
            fail_count <= errs;
        end
    end

endmodule

// ----- tb/link_frame_crc32c_framer_tb.sv -----
`timescale 1ns / 1ps
// Top of the CRC-32C link framer bench: clock, reset, config writes, input
// frames and output back-pressure. Depends on lcf_pkg, the framer RTL and
// lcf_frame_checker, which does all prediction and comparison.
module link_frame_crc32c_framer_tb;
    import lcf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 32;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic                  mode        = MODE_START;
    logic [15:0]           dest_addr   = 16'd0;
    logic [15:0]           src_addr    = 16'd0;
    logic [15:0]           payload_len = 16'd0;
    logic [7:0]            data_byte   = 8'd0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [7:0]            out_byte;
    logic                  frame_end;
    logic                  rejected;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int cycles = 0;
    int cur_max;
    bit calm = 1'b0;

    link_frame_crc32c_framer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .dest_addr(dest_addr), .src_addr(src_addr), .payload_len(payload_len),
        .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
        .frame_end(frame_end), .rejected(rejected),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lcf_frame_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .dest_addr(dest_addr), .src_addr(src_addr), .payload_len(payload_len),
        .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
        .frame_end(frame_end), .rejected(rejected),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // output back-pressure
    initial
    begin
        int r;
        int run;
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            r = $urandom_range(0, 99);
            run = (r < 80) ? $urandom_range(1, 6) : $urandom_range(20, 80);
            repeat (run) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 75)
                stall = $urandom_range(1, 3);
            else if (r < 95)
                stall = $urandom_range(4, 12);
            else
                stall = $urandom_range(30, 60);
            out_ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
    end

    // hold one input item until accepted; returns at the accepting edge, or after a random gap with in_valid low
    task automatic push_item(input logic m, input logic [15:0] dst, input logic [15:0] src,
                             input logic [15:0] len, input logic [7:0] d);
        int gap;
        in_valid    <= 1'b1;
        mode        <= m;
        dest_addr   <= dst;
        src_addr    <= src;
        payload_len <= len;
        data_byte   <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_start(input logic [15:0] dst, input logic [15:0] src,
                              input logic [15:0] len);
        push_item(MODE_START, dst, src, len, 8'($urandom));
    endtask

    task automatic send_data(input logic [7:0] d);
        push_item(MODE_DATA, 16'($urandom), 16'($urandom), 16'($urandom), d);
    endtask

    // wait for the output to drain and the queue to empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // two-phase config write
    task automatic cfg_write(input reg_idx_t r, input logic [CFG_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (r == REG_MAX_PAYLOAD)
            cur_max = int'(v[15:0]);
    endtask

    // one random frame or a stray payload byte; returns items counted
    task automatic random_frame(output int used);
        int r;
        int len;
        int n;
        int lim;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            // stray byte, ignored unless a frame is open
            send_data(8'($urandom));
            used = 0;
        end
        else
        begin
            lim = (cur_max < 12) ? cur_max : 12;
            if (r < 22 && cur_max < 65535)
            begin
                if (cur_max >= 65523)
                    len = $urandom_range(cur_max + 1, 65535);
                else
                    len = cur_max + 1 + $urandom_range(0, 11);
            end
            else if (r < 30)
                len = $urandom_range(0, cur_max);
            else
                len = $urandom_range(0, lim);
            send_start(16'($urandom), 16'($urandom), 16'(len));
            // long frames get cut short by the next start
            n = (len > 12) ? $urandom_range(0, 12) : len;
            if (len > 0 && len <= 12 && $urandom_range(0, 99) < 12)
                n = $urandom_range(0, len - 1);
            repeat (n) send_data(8'($urandom));
            used = 1 + n;
        end
    endtask

    initial
    begin
        int count;
        int used;
        cur_max = int'(MAX_PAYLOAD_RESET);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: empty frame, full frame, stray byte
        send_start(16'h0000, 16'h0000, 16'd0);
        send_start(16'hFFFF, 16'hFFFF, 16'd3);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'hA5);
        send_data(8'h3C);
        // rejection, then a start while dropping
        send_start(16'h1234, 16'hABCD, 16'd4097);
        send_data(8'h11);
        send_start(16'h8001, 16'h0001, 16'd2);
        send_data(8'h7E);
        // start while a frame is open
        send_start(16'h0000, 16'h0000, 16'd0);
        settle();

        // length at the limit and one over it
        cfg_write(REG_SYNC_FIRST, 32'h0000_00FF);
        cfg_write(REG_SYNC_SECOND, 32'h0000_0000);
        cfg_write(REG_MAX_PAYLOAD, 32'd2);
        send_start(16'h5555, 16'hAAAA, 16'd2);
        send_data(8'hFF);
        send_data(8'h00);
        send_start(16'h0F0F, 16'hF0F0, 16'd3);
        repeat (3) send_data(8'($urandom));
        send_data(8'h99);
        settle();

        // zero maximum
        cfg_write(REG_SYNC_FIRST, 32'h0000_0000);
        cfg_write(REG_SYNC_SECOND, 32'h0000_00FF);
        cfg_write(REG_MAX_PAYLOAD, 32'd0);
        send_start(16'hC3C3, 16'h3C3C, 16'd0);
        send_start(16'h0001, 16'h8000, 16'd1);
        send_data(8'h5A);
        settle();

        // full-scale maximum and length
        cfg_write(REG_MAX_PAYLOAD, 32'h0000_FFFF);
        send_start(16'hFFFF, 16'h0000, 16'hFFFF);
        send_data(8'h80);
        send_data(8'h01);
        send_start(16'h0000, 16'hFFFF, 16'd1);
        send_data(8'h42);
        settle();

        // random phases, each under its own setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 5)
                0: cfg_write(REG_MAX_PAYLOAD, 32'd0);
                1: cfg_write(REG_MAX_PAYLOAD, 32'h0000_FFFF);
                2: cfg_write(REG_MAX_PAYLOAD, 32'($urandom_range(1, 16)));
                3: cfg_write(REG_MAX_PAYLOAD, 32'(MAX_PAYLOAD_RESET));
                default: cfg_write(REG_MAX_PAYLOAD, 32'($urandom_range(0, 65535)));
            endcase
            if (ph == 0)
            begin
                cfg_write(REG_SYNC_FIRST, 32'h0000_00FF);
                cfg_write(REG_SYNC_SECOND, 32'h0000_00FF);
            end
            else
            begin
                cfg_write(REG_SYNC_FIRST, 32'($urandom_range(0, 255)));
                cfg_write(REG_SYNC_SECOND, 32'($urandom_range(0, 255)));
            end
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                    calm = !calm;
                random_frame(used);
                count += used;
            end
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- link_frame_crc32c_framer.f -----
rtl/lcf_pkg.sv
rtl/lcf_front.sv
rtl/lcf_cmd_fifo.sv
rtl/lcf_back.sv
rtl/link_frame_crc32c_framer.sv
tb/lcf_frame_checker.sv
tb/link_frame_crc32c_framer_tb.sv
